// File: rtl/blpw_pkg.sv
package blpw_pkg;

  // command codes carried in the input tuser bit
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // frame base after reset
  localparam logic [31:0] FRAME_BASE_RESET = 32'hFFFE_D400;

  // one pixel result from the line engine
  typedef struct packed {
    logic        valid;
    logic        write_enable;
    logic        line_done;
    logic [31:0] pixel_address;
    logic [7:0]  pixel_color;
  } pixel_t;

endpackage

// File: rtl/blpw_engine.sv
module blpw_engine #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240,
  parameter int COORD_BITS    = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic                         command_i,
  input  logic signed [COORD_BITS-1:0] x_start_i,
  input  logic signed [COORD_BITS-1:0] y_start_i,
  input  logic signed [COORD_BITS-1:0] x_end_i,
  input  logic signed [COORD_BITS-1:0] y_end_i,
  input  logic [7:0]                   line_color_i,
  input  logic [31:0]                  frame_base_i,
  output blpw_pkg::pixel_t             res_o
);
  import blpw_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EB = COORD_BITS + 3;
  localparam int MB = COORD_BITS + 11;
  localparam logic [10:0] SW_U = 11'(SCREEN_WIDTH);

  // line state
  logic                 busy_q, busy_d;
  logic                 steep_q, steep_d;
  logic signed [CB-1:0] cur_col_q, cur_col_d;
  logic signed [CB-1:0] cur_row_q, cur_row_d;
  logic signed [CB-1:0] major_end_q, major_end_d;
  logic                 minor_neg_q, minor_neg_d;
  logic [CB-1:0]        delta_major_q, delta_major_d;
  logic [CB-1:0]        delta_minor_q, delta_minor_d;
  logic signed [EB-1:0] error_q, error_d;
  logic [7:0]           color_q, color_d;

  // setup signals
  logic signed [CB:0]   dx, dy, dmaj_full;
  logic [CB:0]          adx_full, ady_full;
  logic [CB-1:0]        adx, ady, dmaj, dmin;
  logic                 steep_new, swap;
  logic signed [CB-1:0] x0s, y0s, x1s, y1s;

  // step signals
  logic signed [CB-1:0] major_cur;
  logic                 done, on_screen, err_pos;
  logic [CB-1:0]        col_u, row_u;
  logic [MB-1:0]        row_offset;
  logic signed [CB-1:0] minor_cur, minor_next;

  // load setup: octant, endpoint order, deltas and error term
  always_comb begin
    dx        = (CB+1)'(x_end_i) - (CB+1)'(x_start_i);
    dy        = (CB+1)'(y_end_i) - (CB+1)'(y_start_i);
    adx_full  = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
    ady_full  = dy[CB] ? $unsigned(-dy) : $unsigned(dy);
    adx       = adx_full[CB-1:0];
    ady       = ady_full[CB-1:0];
    steep_new = !(ady < adx);
    swap      = steep_new ? (y_start_i > y_end_i) : (x_start_i > x_end_i);
    x0s       = swap ? x_end_i   : x_start_i;
    y0s       = swap ? y_end_i   : y_start_i;
    x1s       = swap ? x_start_i : x_end_i;
    y1s       = swap ? y_start_i : y_end_i;
    dmaj_full = steep_new ? ((CB+1)'(y1s) - (CB+1)'(y0s))
                          : ((CB+1)'(x1s) - (CB+1)'(x0s));
    dmaj      = dmaj_full[CB-1:0];
    dmin      = steep_new ? adx : ady;
  end

  // tick: screen test, address, end test and the next error step
  always_comb begin
    major_cur  = steep_q ? cur_row_q : cur_col_q;
    done       = major_cur >= major_end_q;
    col_u      = $unsigned(cur_col_q);
    row_u      = $unsigned(cur_row_q);
    on_screen  = !cur_col_q[CB-1] && !cur_row_q[CB-1] &&
                 (32'(col_u) < 32'(SCREEN_WIDTH)) &&
                 (32'(row_u) < 32'(SCREEN_HEIGHT));
    row_offset = MB'(row_u) * MB'(SW_U);
    err_pos    = !error_q[EB-1] && (error_q != '0);
    minor_cur  = steep_q ? cur_col_q : cur_row_q;
    minor_next = minor_neg_q ? (minor_cur - CB'(1)) : (minor_cur + CB'(1));

    res_o.valid         = fire_i && (command_i == CMD_TICK) && busy_q;
    res_o.write_enable  = on_screen;
    res_o.line_done     = done;
    res_o.pixel_address = on_screen ? (frame_base_i + 32'(col_u) + 32'(row_offset)) : '0;
    res_o.pixel_color   = color_q;
  end

  // next line state
  always_comb begin
    busy_d        = busy_q;
    steep_d       = steep_q;
    cur_col_d     = cur_col_q;
    cur_row_d     = cur_row_q;
    major_end_d   = major_end_q;
    minor_neg_d   = minor_neg_q;
    delta_major_d = delta_major_q;
    delta_minor_d = delta_minor_q;
    error_d       = error_q;
    color_d       = color_q;
    if (fire_i && (command_i == CMD_LOAD)) begin
      busy_d        = 1'b1;
      steep_d       = steep_new;
      cur_col_d     = x0s;
      cur_row_d     = y0s;
      major_end_d   = steep_new ? y1s : x1s;
      minor_neg_d   = steep_new ? (x1s < x0s) : (y1s < y0s);
      delta_major_d = dmaj;
      delta_minor_d = dmin;
      error_d       = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
      color_d       = line_color_i;
    end else if (res_o.valid) begin
      if (done) begin
        busy_d = 1'b0;
      end else begin
        if (err_pos) begin
          if (steep_q) begin
            cur_col_d = minor_next;
          end else begin
            cur_row_d = minor_next;
          end
          error_d = error_q + $signed({2'b00, delta_minor_q, 1'b0})
                            - $signed({2'b00, delta_major_q, 1'b0});
        end else begin
          error_d = error_q + $signed({2'b00, delta_minor_q, 1'b0});
        end
        if (steep_q) begin
          cur_row_d = cur_row_q + CB'(1);
        end else begin
          cur_col_d = cur_col_q + CB'(1);
        end
      end
    end
  end

  // busy is the only register with a reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // line registers
  always_ff @(posedge clk_i) begin
    steep_q       <= steep_d;
    cur_col_q     <= cur_col_d;
    cur_row_q     <= cur_row_d;
    major_end_q   <= major_end_d;
    minor_neg_q   <= minor_neg_d;
    delta_major_q <= delta_major_d;
    delta_minor_q <= delta_minor_d;
    error_q       <= error_d;
    color_q       <= color_d;
  end

`ifndef SYNTHESIS
  a_load_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && command_i == CMD_LOAD) |=> busy_q)
    else $error("load did not start a line");

  a_done_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.line_done) |=> !busy_q)
    else $error("line still active after final pixel");

  a_step_keeps_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.line_done) |=> busy_q)
    else $error("line ended before final pixel");

  a_clipped_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.write_enable) |-> (res_o.pixel_address == 32'd0))
    else $error("clipped pixel carries an address");
`endif

endmodule

// File: rtl/bresenham_line_pixel_writer.sv
// Bresenham line pixel writer. A load item (tuser 0) latches two endpoints and a colour and
// produces no output; each tick item (tuser 1) emits the next pixel of the active line as a
// frame-buffer address (frame base + column + row * screen width) and colour, with tuser
// flagging an on-screen write and tlast the final pixel. Off-screen pixels come out with
// tuser 0 and address 0; a tick with no line active produces nothing. One item is taken
// every cycle unless the output stalls: an input register feeds a line engine whose state
// update closes the per-pixel loop, followed by an output register. The user must write
// frame_base through cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
module bresenham_line_pixel_writer #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240,
  parameter int COORD_BITS    = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // fields from bit 0: x_start, y_start, x_end, y_end, line_color, zero pad
  input  logic [((4*COORD_BITS+15)/8)*8-1:0]   s_axis_tdata,
  // fields from bit 0: command
  input  logic                                 s_axis_tuser,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // fields from bit 0: pixel_address, pixel_color
  output logic [39:0]                          m_axis_tdata,
  // fields from bit 0: write_enable
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_we_i,
  input  logic [31:0]                          cfg_wdata_i
);
  import blpw_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int FB = 4 * COORD_BITS + 8;

  logic          in_v_q, in_v_d;
  logic          in_cmd_q;
  logic [FB-1:0] in_data_q;
  logic          out_v_q, out_v_d;
  pixel_t        out_q;
  pixel_t        res;
  logic          advance;
  logic [31:0]   frame_base_q;

  // handshake: the engine moves when an input item is held and the output slot is free or draining
  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;

  always_comb begin
    in_v_d = in_v_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_v_d = 1'b1;
    end else if (advance) begin
      in_v_d = 1'b0;
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (advance) begin
      out_v_d = res.valid;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
  end

  // control registers and frame base
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
      frame_base_q <= FRAME_BASE_RESET;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
      if (cfg_we_i) begin
        frame_base_q <= cfg_wdata_i;
      end
    end
  end

  // input item register
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q  <= s_axis_tuser;
      in_data_q <= s_axis_tdata[FB-1:0];
    end
  end

  // line engine
  blpw_engine #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .COORD_BITS    (COORD_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance),
    .command_i    (in_cmd_q),
    .x_start_i    ($signed(in_data_q[CB-1:0])),
    .y_start_i    ($signed(in_data_q[2*CB-1:CB])),
    .x_end_i      ($signed(in_data_q[3*CB-1:2*CB])),
    .y_end_i      ($signed(in_data_q[4*CB-1:3*CB])),
    .line_color_i (in_data_q[4*CB+7:4*CB]),
    .frame_base_i (frame_base_q),
    .res_o        (res)
  );

  // output item register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.pixel_color, out_q.pixel_address};
  assign m_axis_tuser  = out_q.write_enable;
  assign m_axis_tlast  = out_q.line_done;

endmodule
